@@ rtl/core/lrm_pkg.sv @@
// Shared types and constants for the label region moments block.
package lrm_pkg;

	// Field widths of the pixel request and the moment result
	localparam int LABEL_W = 8;
	localparam int COORD_W = 15;
	localparam int AREA_W = 30;
	localparam int SUM1_W = 46;
	localparam int SUM2_W = 61;
	localparam int PROD_W = 2 * COORD_W;
	localparam int RES_FIELDS_W = AREA_W + 2 * SUM1_W + 3 * SUM2_W;
	localparam int RES_W = ((RES_FIELDS_W + 7) / 8) * 8;
	localparam int RES_PAD_W = RES_W - RES_FIELDS_W;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = COORD_W;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_LABEL = 2'd2;

	// Result queue sizing
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = 2;
	localparam int RES_CNT_W = 3;

	// Pixel after position tracking and label compare
	typedef struct packed {
		logic valid;
		logic match;
		logic frame_end;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} pix_s1_t;

	// Pixel with its coordinate products
	typedef struct packed {
		logic valid;
		logic match;
		logic frame_end;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [PROD_W-1:0] col_sq;
		logic [PROD_W-1:0] col_row;
		logic [PROD_W-1:0] row_sq;
	} pix_s2_t;

	// Result word; the first field sits in the lowest bits
	typedef struct packed {
		logic [RES_PAD_W-1:0] pad;
		logic [SUM2_W-1:0] sum_row_sq;
		logic [SUM2_W-1:0] sum_col_row;
		logic [SUM2_W-1:0] sum_col_sq;
		logic [SUM1_W-1:0] sum_row;
		logic [SUM1_W-1:0] sum_col;
		logic [AREA_W-1:0] area;
	} res_t;

endpackage

@@ rtl/core/lrm_position.sv @@
// Raster position counters, label compare and the first pipeline register.
module lrm_position #(
	parameter int MAX_SIDE = 32767
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_fire,
	input  logic [lrm_pkg::LABEL_W-1:0] label,
	input  logic [lrm_pkg::COORD_W-1:0] image_width,
	input  logic [lrm_pkg::COORD_W-1:0] image_height,
	input  logic [lrm_pkg::LABEL_W-1:0] target_label,
	output lrm_pkg::pix_s1_t pix_s1
);
	import lrm_pkg::*;

	localparam logic [COORD_W-1:0] SIDE_MAX = COORD_W'(MAX_SIDE);
	localparam logic [COORD_W-1:0] SIDE_ONE = COORD_W'(1);

	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] width_eff;
	logic [COORD_W-1:0] height_eff;
	logic [COORD_W:0] col_inc;
	logic [COORD_W:0] row_inc;
	logic row_end;
	logic frame_end;

	// Zero sizes act as one, oversize acts as the largest side
	always_comb begin
		if (image_width == '0) begin
			width_eff = SIDE_ONE;
		end else if (image_width > SIDE_MAX) begin
			width_eff = SIDE_MAX;
		end else begin
			width_eff = image_width;
		end
		if (image_height == '0) begin
			height_eff = SIDE_ONE;
		end else if (image_height > SIDE_MAX) begin
			height_eff = SIDE_MAX;
		end else begin
			height_eff = image_height;
		end
	end

	// Row and frame ends against the current size registers
	assign col_inc = {1'b0, col_q} + (COORD_W+1)'(1);
	assign row_inc = {1'b0, row_q} + (COORD_W+1)'(1);
	assign row_end = col_inc >= {1'b0, width_eff};
	assign frame_end = row_end && (row_inc >= {1'b0, height_eff});

	// Position of the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_fire) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_inc[COORD_W-1:0];
			end else begin
				col_q <= col_inc[COORD_W-1:0];
			end
		end
	end

	// First pipeline register; the payload loads only with an accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= '0;
		end else begin
			pix_s1.valid <= pix_fire;
			if (pix_fire) begin
				pix_s1.match <= (label == target_label);
				pix_s1.frame_end <= frame_end;
				pix_s1.col <= col_q;
				pix_s1.row <= row_q;
			end
		end
	end

endmodule

@@ rtl/core/lrm_products.sv @@
// Coordinate products and the second pipeline register.
module lrm_products (
	input  logic clk,
	input  logic arst_n,
	input  lrm_pkg::pix_s1_t pix_s1,
	output lrm_pkg::pix_s2_t pix_s2
);
	import lrm_pkg::*;

	// Valid flag follows the first stage; one 15x15 product per moment term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s2 <= '0;
		end else begin
			pix_s2.valid <= pix_s1.valid;
			if (pix_s1.valid) begin
				pix_s2.match <= pix_s1.match;
				pix_s2.frame_end <= pix_s1.frame_end;
				pix_s2.col <= pix_s1.col;
				pix_s2.row <= pix_s1.row;
				pix_s2.col_sq <= PROD_W'(pix_s1.col) * PROD_W'(pix_s1.col);
				pix_s2.col_row <= PROD_W'(pix_s1.col) * PROD_W'(pix_s1.row);
				pix_s2.row_sq <= PROD_W'(pix_s1.row) * PROD_W'(pix_s1.row);
			end
		end
	end

endmodule

@@ rtl/core/lrm_accum.sv @@
// Moment accumulators; a frame end pushes the sums and clears them.
module lrm_accum (
	input  logic clk,
	input  logic arst_n,
	input  lrm_pkg::pix_s2_t pix_s2,
	output logic push,
	output lrm_pkg::res_t push_data
);
	import lrm_pkg::*;

	logic [AREA_W-1:0] acc_area_q;
	logic [SUM1_W-1:0] acc_col_q;
	logic [SUM1_W-1:0] acc_row_q;
	logic [SUM2_W-1:0] acc_col_sq_q;
	logic [SUM2_W-1:0] acc_col_row_q;
	logic [SUM2_W-1:0] acc_row_sq_q;
	logic add_en;

	assign add_en = pix_s2.valid && pix_s2.match;

	// Sums including the current pixel
	always_comb begin
		push_data = '0;
		push_data.area = acc_area_q + AREA_W'(add_en);
		push_data.sum_col = acc_col_q + (add_en ? SUM1_W'(pix_s2.col) : '0);
		push_data.sum_row = acc_row_q + (add_en ? SUM1_W'(pix_s2.row) : '0);
		push_data.sum_col_sq = acc_col_sq_q + (add_en ? SUM2_W'(pix_s2.col_sq) : '0);
		push_data.sum_col_row = acc_col_row_q + (add_en ? SUM2_W'(pix_s2.col_row) : '0);
		push_data.sum_row_sq = acc_row_sq_q + (add_en ? SUM2_W'(pix_s2.row_sq) : '0);
	end

	assign push = pix_s2.valid && pix_s2.frame_end;

	// Running sums, cleared after the last pixel of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_area_q <= '0;
			acc_col_q <= '0;
			acc_row_q <= '0;
			acc_col_sq_q <= '0;
			acc_col_row_q <= '0;
			acc_row_sq_q <= '0;
		end else if (push) begin
			acc_area_q <= '0;
			acc_col_q <= '0;
			acc_row_q <= '0;
			acc_col_sq_q <= '0;
			acc_col_row_q <= '0;
			acc_row_sq_q <= '0;
		end else if (pix_s2.valid) begin
			acc_area_q <= push_data.area;
			acc_col_q <= push_data.sum_col;
			acc_row_q <= push_data.sum_row;
			acc_col_sq_q <= push_data.sum_col_sq;
			acc_col_row_q <= push_data.sum_col_row;
			acc_row_sq_q <= push_data.sum_row_sq;
		end
	end

endmodule

@@ rtl/core/lrm_result_fifo.sv @@
// Small result queue between the accumulators and the output stream.
module lrm_result_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  lrm_pkg::res_t push_data,
	input  logic pop,
	output logic not_empty,
	output lrm_pkg::res_t head,
	output logic [lrm_pkg::RES_CNT_W-1:0] count
);
	import lrm_pkg::*;

	res_t entry_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_CNT_W-1:0] count_q;

	assign count = count_q;
	assign not_empty = (count_q != '0);
	assign head = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + RES_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - RES_CNT_W'(1);
			end
		end
	end

	// Result storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/label_region_moments.sv @@
// Top level of the label region moments block.
// Takes a label image as a raster stream, one label byte per request, and sums
// the count, column, row, column squared, column times row and row squared of
// every pixel whose label equals target_label. After the last pixel of a frame
// one result request carries the six sums, which then restart from zero. A pixel
// is accepted every clock unless the queue stalls it; a result becomes valid
// once its last pixel has passed the position stage, then the product stage,
// whose accumulator sum is written straight into the result queue. The four-entry
// result queue sets the only stall: a pixel is refused while the queue entries
// together with frame ends still in the pipeline already reach four, so with
// a ready sink the rate stays at one pixel per clock even for 1x1 frames.
// Size or label writes take effect on the next accepted pixel.
module label_region_moments #(
	parameter int MAX_SIDE = 32767
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [lrm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lrm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,     // label[7:0]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// area, sum_col, sum_row, sum_col_sq, sum_col_row, sum_row_sq, zero pad
	output logic [lrm_pkg::RES_W-1:0] m_axis_tdata
);
	import lrm_pkg::*;

	logic [COORD_W-1:0] image_width_q;
	logic [COORD_W-1:0] image_height_q;
	logic [LABEL_W-1:0] target_label_q;
	logic pix_fire;
	logic res_pop;
	logic res_push;
	res_t res_push_data;
	res_t res_head;
	logic [RES_CNT_W-1:0] res_count;
	logic [RES_CNT_W-1:0] res_claimed;
	pix_s1_t pix_s1;
	pix_s2_t pix_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= COORD_W'(1);
			image_height_q <= COORD_W'(1);
			target_label_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: image_width_q <= cfg_wdata;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata;
				REG_TARGET_LABEL: target_label_q <= cfg_wdata[LABEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Queue entries held plus those owed to frame ends in flight
	assign res_claimed = res_count
		+ RES_CNT_W'(pix_s1.valid && pix_s1.frame_end)
		+ RES_CNT_W'(pix_s2.valid && pix_s2.frame_end);
	assign s_axis_tready = (res_claimed < RES_CNT_W'(RES_DEPTH));
	assign pix_fire = s_axis_tvalid && s_axis_tready;
	assign res_pop = m_axis_tvalid && m_axis_tready;

	lrm_position #(
		.MAX_SIDE(MAX_SIDE)
	) u_position (
		.clk(clk),
		.arst_n(arst_n),
		.pix_fire(pix_fire),
		.label(s_axis_tdata[LABEL_W-1:0]),
		.image_width(image_width_q),
		.image_height(image_height_q),
		.target_label(target_label_q),
		.pix_s1(pix_s1)
	);

	lrm_products u_products (
		.clk(clk),
		.arst_n(arst_n),
		.pix_s1(pix_s1),
		.pix_s2(pix_s2)
	);

	lrm_accum u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.pix_s2(pix_s2),
		.push(res_push),
		.push_data(res_push_data)
	);

	lrm_result_fifo u_result_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.push_data(res_push_data),
		.pop(res_pop),
		.not_empty(m_axis_tvalid),
		.head(res_head),
		.count(res_count)
	);

	assign m_axis_tdata = res_head;

	// The queue never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_count <= RES_CNT_W'(RES_DEPTH))
		else $error("result queue count above depth");

	// Frame ends in flight never overcommit the queue
	a_claim_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_claimed <= RES_CNT_W'(RES_DEPTH))
		else $error("result queue overcommitted");

	// A push never lands on a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res_count < RES_CNT_W'(RES_DEPTH)) || res_pop)
		else $error("result pushed into full queue");

	// A frame end in the first pipeline register is pushed into the queue from the product stage
	a_frame_end_push: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_s1.valid && pix_s1.frame_end) |=> res_push)
		else $error("frame end lost in pipeline");

endmodule
